// ===== src/sce_pkg.sv =====
// sce_pkg: shared types and constants for the spinal-code encoder
// holds the controller states, the command/status structs and the hash constants
// no dependencies

package sce_pkg;

    localparam int DEF_MAX_SYMBOLS_PER_ITEM = 64;
    localparam int DEF_MAX_CHUNK_BITS       = 16;

    localparam int CHUNK_W     = 16;
    localparam int CODE_W      = 32;
    localparam int INDEX_W     = 6;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 64;
    localparam int KBITS_W     = 5;
    localparam int BBITS_W     = 6;
    localparam int NSYM_W      = 7;
    localparam int SPINE_W     = 64;
    localparam int HALF_W      = 32;

    localparam logic [63:0] SEED_RESET = 64'h5A5A_5A5A_5A5A_5A5A;
    localparam logic [63:0] MIX_C1     = 64'hFF51_AFD7_ED55_8CCD;
    localparam logic [63:0] MIX_C2     = 64'hC4CE_B9FE_1A85_EC53;
    localparam logic [63:0] SYM_GOLD   = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [63:0] SYM_C      = 64'h0FC9_4E3B_F4A8_EC29;

    localparam int SPINE_SHIFT = 33;
    localparam int SYM_SHIFT_A = 17;
    localparam int SYM_SHIFT_B = 13;

    localparam logic [KBITS_W-1:0] CHUNK_BITS_RESET = 5'd4;
    localparam logic [BBITS_W-1:0] SYMBOL_BITS_RESET = 6'd8;
    localparam logic [NSYM_W-1:0]  SYMS_PER_SPINE_RESET = 7'd8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CHUNK_BITS        = 2'd0,
        REG_SYMBOL_BITS       = 2'd1,
        REG_HASH_SEED         = 2'd2,
        REG_SYMBOLS_PER_SPINE = 2'd3
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MIX1,
        ST_MUL2,
        ST_SPINE,
        ST_SYM,
        ST_MUL3,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        CSEL_MIX1,
        CSEL_MIX2,
        CSEL_SYM
    } const_sel_t;

    // low 64 bits of the 64x64 product are built from three 32x32 partial products
    localparam logic [1:0] MUL_PH_LL   = 2'd0;
    localparam logic [1:0] MUL_PH_LH   = 2'd1;
    localparam logic [1:0] MUL_PH_HL   = 2'd2;

    typedef struct packed {
        logic       load;
        logic       mul_en;
        logic [1:0] mul_phase;
        const_sel_t mul_sel;
        logic       mix1;
        logic       spine_en;
        logic       sym_prep;
        logic       emit;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
        logic sym_last;
    } dp_stat_t;

    function automatic logic [63:0] fold(input logic [63:0] v, input int sh);
        fold = v ^ (v >> sh);
    endfunction

endpackage

// ===== src/sce_ctrl.sv =====
// sce_ctrl: sequencing state machine of the spinal-code encoder
// drives datapath commands, steps the shared multiplier through its phases
// depends on sce_pkg

module sce_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  sce_pkg::dp_stat_t stat,
    output sce_pkg::dp_cmd_t  cmd
);
    import sce_pkg::*;

    state_t     state_reg, state_next;
    logic [1:0] phase_reg, phase_next;
    logic       in_accept;
    logic       mul_state;
    logic       mul_done;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign mul_state = (state_reg == ST_MUL1) || (state_reg == ST_MUL2)
                    || (state_reg == ST_MUL3);
    assign mul_done  = (phase_reg == MUL_PH_HL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= MUL_PH_LL;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    always_comb
    begin
        phase_next = MUL_PH_LL;
        if (mul_state && !mul_done)
        begin
            phase_next = phase_reg + 2'd1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_MUL1;
                end
            end
            ST_MUL1:
            begin
                if (mul_done)
                begin
                    state_next = ST_MIX1;
                end
            end
            ST_MIX1:  state_next = ST_MUL2;
            ST_MUL2:
            begin
                if (mul_done)
                begin
                    state_next = ST_SPINE;
                end
            end
            ST_SPINE: state_next = ST_SYM;
            ST_SYM:   state_next = ST_MUL3;
            ST_MUL3:
            begin
                if (mul_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    state_next = stat.sym_last ? ST_IDLE : ST_SYM;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd           = '0;
        cmd.mul_sel   = CSEL_MIX1;
        cmd.mul_phase = phase_reg;
        case (state_reg)
            ST_IDLE:  cmd.load = in_accept;
            ST_MUL1:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = CSEL_MIX1;
            end
            ST_MIX1:  cmd.mix1 = 1'b1;
            ST_MUL2:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = CSEL_MIX2;
            end
            ST_SPINE: cmd.spine_en = 1'b1;
            ST_SYM:   cmd.sym_prep = 1'b1;
            ST_MUL3:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = CSEL_SYM;
            end
            ST_EMIT:  cmd.emit = stat.out_free;
            default:  cmd.load = 1'b0;
        endcase
    end

endmodule

// ===== src/sce_dp.sv =====
// sce_dp: datapath of the spinal-code encoder
// config registers, spine, shared 32x32 multiplier, symbol counter, output word register
// depends on sce_pkg

module sce_dp #(
    parameter int MAX_SYMBOLS_PER_ITEM = sce_pkg::DEF_MAX_SYMBOLS_PER_ITEM,
    parameter int MAX_CHUNK_BITS       = sce_pkg::DEF_MAX_CHUNK_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [sce_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sce_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic [sce_pkg::CHUNK_W-1:0]    chunk,
    input  logic                           first,
    input  sce_pkg::dp_cmd_t               cmd,
    output sce_pkg::dp_stat_t              stat,
    input  logic                           out_stall,
    output logic                           out_valid,
    output logic [sce_pkg::CODE_W-1:0]     symbol_code,
    output logic [sce_pkg::INDEX_W-1:0]    symbol_index,
    output logic                           last
);
    import sce_pkg::*;

    logic [KBITS_W-1:0]  chunk_bits_reg;
    logic [BBITS_W-1:0]  symbol_bits_reg;
    logic [SPINE_W-1:0]  hash_seed_reg;
    logic [NSYM_W-1:0]   syms_per_spine_reg;

    logic [SPINE_W-1:0]  spine_reg, spine_next;
    logic [SPINE_W-1:0]  x_reg, x_next;
    logic [SPINE_W-1:0]  acc_reg, acc_next;
    logic [SPINE_W-1:0]  gold_reg, gold_next;
    logic [INDEX_W-1:0]  j_reg, j_next;
    logic                out_valid_reg, out_valid_next;
    logic [CODE_W-1:0]   code_reg;
    logic [INDEX_W-1:0]  index_reg;
    logic                last_reg;

    logic [KBITS_W-1:0]  k_eff;
    logic [BBITS_W-1:0]  b_eff;
    logic [NSYM_W-1:0]   n_eff;
    logic [CHUNK_W-1:0]  chunk_mask;
    logic [SPINE_W-1:0]  load_base;
    logic [SPINE_W-1:0]  sym_base;
    logic [SPINE_W-1:0]  sym_r;
    logic [HALF_W-1:0]   shift_src;
    logic [4:0]          code_shamt;
    logic [SPINE_W-1:0]  mul_c;
    logic [HALF_W-1:0]   mul_a, mul_b;
    logic [SPINE_W-1:0]  prod;

    // register file; the user must write it only while idle, the block itself does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chunk_bits_reg     <= CHUNK_BITS_RESET;
            symbol_bits_reg    <= SYMBOL_BITS_RESET;
            hash_seed_reg      <= SEED_RESET;
            syms_per_spine_reg <= SYMS_PER_SPINE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CHUNK_BITS:        chunk_bits_reg     <= cfg_data[KBITS_W-1:0];
                REG_SYMBOL_BITS:       symbol_bits_reg    <= cfg_data[BBITS_W-1:0];
                REG_HASH_SEED:         hash_seed_reg      <= cfg_data;
                REG_SYMBOLS_PER_SPINE: syms_per_spine_reg <= cfg_data[NSYM_W-1:0];
                default:               hash_seed_reg      <= hash_seed_reg;
            endcase
        end
    end

    // out-of-range settings saturate
    always_comb
    begin
        if (chunk_bits_reg == '0)
            k_eff = KBITS_W'(1);
        else if (32'(chunk_bits_reg) > MAX_CHUNK_BITS)
            k_eff = KBITS_W'(MAX_CHUNK_BITS);
        else
            k_eff = chunk_bits_reg;

        if (symbol_bits_reg == '0)
            b_eff = BBITS_W'(1);
        else if (symbol_bits_reg > BBITS_W'(CODE_W))
            b_eff = BBITS_W'(CODE_W);
        else
            b_eff = symbol_bits_reg;

        if (syms_per_spine_reg == '0)
            n_eff = NSYM_W'(1);
        else if (32'(syms_per_spine_reg) > MAX_SYMBOLS_PER_ITEM)
            n_eff = NSYM_W'(MAX_SYMBOLS_PER_ITEM);
        else
            n_eff = syms_per_spine_reg;
    end

    always_comb
    begin
        for (int i = 0; i < CHUNK_W; i++)
        begin
            chunk_mask[i] = (KBITS_W'(i) < k_eff);
        end
    end

    assign load_base = first ? hash_seed_reg : spine_reg;
    assign sym_base  = spine_reg ^ gold_reg;

    // shared multiplier: low 64 bits of x * c over three phases
    always_comb
    begin
        case (cmd.mul_sel)
            CSEL_MIX1: mul_c = MIX_C1;
            CSEL_MIX2: mul_c = MIX_C2;
            CSEL_SYM:  mul_c = SYM_C;
            default:   mul_c = SYM_C;
        endcase
    end

    assign mul_a = (cmd.mul_phase == MUL_PH_HL) ? x_reg[SPINE_W-1:HALF_W] : x_reg[HALF_W-1:0];
    assign mul_b = (cmd.mul_phase == MUL_PH_LH) ? mul_c[SPINE_W-1:HALF_W] : mul_c[HALF_W-1:0];
    assign prod  = SPINE_W'(mul_a) * SPINE_W'(mul_b);

    // symbol code: top b bits of the final mix
    assign sym_r      = fold(acc_reg, SYM_SHIFT_B);
    assign shift_src  = sym_r[SPINE_W-1:HALF_W];
    assign code_shamt = 5'(BBITS_W'(CODE_W) - b_eff);

    assign stat.out_free = !out_valid_reg || !out_stall;
    assign stat.sym_last = ((NSYM_W'(j_reg) + NSYM_W'(1)) == n_eff);

    always_comb
    begin
        spine_next     = spine_reg;
        x_next         = x_reg;
        acc_next       = acc_reg;
        gold_next      = gold_reg;
        j_next         = j_reg;
        out_valid_next = out_valid_reg && out_stall;

        if (cmd.load)
        begin
            x_next    = fold(load_base ^ SPINE_W'(chunk & chunk_mask), SPINE_SHIFT);
            gold_next = '0;
            j_next    = '0;
        end
        if (cmd.mul_en)
        begin
            if (cmd.mul_phase == MUL_PH_LL)
                acc_next = prod;
            else
                acc_next = {acc_reg[SPINE_W-1:HALF_W] + prod[HALF_W-1:0],
                            acc_reg[HALF_W-1:0]};
        end
        if (cmd.mix1)
        begin
            x_next = fold(acc_reg, SPINE_SHIFT);
        end
        if (cmd.spine_en)
        begin
            spine_next = fold(acc_reg, SPINE_SHIFT);
        end
        if (cmd.sym_prep)
        begin
            x_next = fold(sym_base, SYM_SHIFT_A);
        end
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            j_next         = j_reg + INDEX_W'(1);
            gold_next      = gold_reg + SYM_GOLD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spine_reg     <= SEED_RESET;
            j_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            spine_reg     <= spine_next;
            j_reg         <= j_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        acc_reg  <= acc_next;
        gold_reg <= gold_next;
        if (cmd.emit)
        begin
            code_reg  <= shift_src >> code_shamt;
            index_reg <= j_reg;
            last_reg  <= stat.sym_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign symbol_code  = code_reg;
    assign symbol_index = index_reg;
    assign last         = last_reg;

endmodule

// ===== src/spinal_code_encoder_top.sv =====
// channel | direction | handshake           | payload
// in      | input     | in_valid / in_stall   | chunk, first
// out     | output    | out_valid / out_stall | symbol_code, symbol_index, last
// cfg     | input     | cfg_we               | cfg_index, cfg_data
//
// one chunk at a time; symbols per spine default to 8
// the single shared 32x32 multiplier builds each 64-bit product in three passes,
// two products per spine update and one per symbol
// async active-low reset loads the register defaults and the seed into the spine
// a stalled output word holds; the next symbol is computed behind it and waits in EMIT
//
// top level: joins the controller and the datapath; depends on sce_pkg, sce_ctrl, sce_dp

module spinal_code_encoder_top #(
    parameter int MAX_SYMBOLS_PER_ITEM = sce_pkg::DEF_MAX_SYMBOLS_PER_ITEM,
    parameter int MAX_CHUNK_BITS       = sce_pkg::DEF_MAX_CHUNK_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [sce_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sce_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [sce_pkg::CHUNK_W-1:0]    chunk,
    input  logic                           first,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [sce_pkg::CODE_W-1:0]     symbol_code,
    output logic [sce_pkg::INDEX_W-1:0]    symbol_index,
    output logic                           last
);
    import sce_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    sce_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    sce_dp #(
        .MAX_SYMBOLS_PER_ITEM (MAX_SYMBOLS_PER_ITEM),
        .MAX_CHUNK_BITS       (MAX_CHUNK_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .chunk        (chunk),
        .first        (first),
        .cmd          (cmd),
        .stat         (stat),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .symbol_code  (symbol_code),
        .symbol_index (symbol_index),
        .last         (last)
    );

endmodule

// ===== src/sce_checker.sv =====
// sce_checker: port-level checks for the spinal-code encoder
// bound to spinal_code_encoder_top; depends on sce_pkg

module sce_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_stall,
    input logic                           out_valid,
    input logic                           out_stall,
    input logic [sce_pkg::CODE_W-1:0]     symbol_code,
    input logic [sce_pkg::INDEX_W-1:0]    symbol_index,
    input logic                           last
);
    import sce_pkg::*;

    // stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(symbol_code)
            && $stable(symbol_index) && $stable(last))
        else $error("stalled output word changed");

    // a chunk is busy until its last symbol has been produced
    a_busy_mid_chunk: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> in_stall)
        else $error("input taken while a chunk still has symbols to send");

    // symbol numbers count up within a chunk
    a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last |=>
            !out_valid || (symbol_index == INDEX_W'($past(symbol_index) + INDEX_W'(1))))
        else $error("symbol index skipped");

    // a new chunk starts at symbol zero
    a_index_restart: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && last |=> !out_valid || (symbol_index == '0))
        else $error("chunk did not start at symbol zero");

    // one chunk at a time
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second chunk taken while busy");

endmodule

bind spinal_code_encoder_top sce_checker u_sce_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .symbol_code  (symbol_code),
    .symbol_index (symbol_index),
    .last         (last)
);
